// File: rtl/scan_polar_to_cartesian_core_assert.svh
// Assertion macros for the scan converter. Each use sits on a line of its own.
// The bodies refer to clk and rst of the module that includes this file.
`ifndef SCAN_POLAR_TO_CARTESIAN_CORE_ASSERT_SVH
`define SCAN_POLAR_TO_CARTESIAN_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SPC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scan converter assertion failed");
`define SPC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scan converter assertion failed");
`else
`define SPC_ASSERT_NOW(name, ante, cons)
`define SPC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// File: rtl/spc_pkg.sv
`timescale 1ns / 1ps
package spc_pkg;

  localparam int ROW_LIMIT    = 512;
  localparam int COLUMN_LIMIT = 512;
  localparam int PHASE_BITS   = 16;

  localparam int ROW_CNT_W   = 10;
  localparam int COL_CNT_W   = 10;
  localparam int CFG_INDEX_W = 3;

  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_W     = 34;

  localparam logic signed [15:0] END_OF_ROW = 16'sd9999;
  localparam logic [20:0]        Z_MAX      = 21'h1FFFFF;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN  = CORDIC_W'(64'sd652032874);
  localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = CORDIC_W'(64'sd1073741824);
  localparam logic signed [CORDIC_W-1:0] HALF_TURN    = CORDIC_W'(64'sd2147483648);

  // arctan(2^-i) in 2^-32 turns
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
  };

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_OFFSET  = 3'd0,
    REG_Z_STEP         = 3'd1,
    REG_MAX_RADIUS     = 3'd2,
    REG_MIN_RADIUS     = 3'd3,
    REG_ANGLE_STEP     = 3'd4,
    REG_POINTS_PER_ROW = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] ang;
  } cordic_vec_t;

  typedef struct packed {
    logic signed [15:0] radius;
    logic               point_valid;
    logic               flip;
    logic [20:0]        z_pos;
    logic [8:0]         row_number;
    logic [8:0]         column_number;
  } pt_info_t;

endpackage

// File: rtl/scan_polar_to_cartesian_core.sv
`timescale 1ns / 1ps
// Throughput: one sample per cycle while the output is taken or some stage
// is empty. The pipeline holds an input register, 20 CORDIC stages, a multiply
// stage and a rounding stage. Row delimiters and dropped samples leave no
// point. Stalled stages close up bubbles.
// Reset (synchronous): counters, row-full flag and stage valid bits clear,
// configuration registers return to their defaults.
module scan_polar_to_cartesian_core import spc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [15:0]     raw_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [19:0]     x_pos,
  output logic signed [19:0]     y_pos,
  output logic [20:0]            z_pos,
  output logic                   point_valid,
  output logic [8:0]             row_number,
  output logic [8:0]             column_number,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  localparam int MUL_STAGE = CORDIC_STEPS + 1;
  localparam int NS        = CORDIC_STEPS + 3;

  logic signed [15:0]    center_offset;
  logic [11:0]           z_step;
  logic signed [15:0]    max_radius;
  logic signed [15:0]    min_radius;
  logic [15:0]           angle_step;
  logic [9:0]            points_per_row;

  logic [ROW_CNT_W-1:0]  row_counter;
  logic [COL_CNT_W-1:0]  column_counter;
  logic [PHASE_BITS-1:0] phase_accumulator;
  logic                  rows_full;

  logic [NS-1:0]         vld;
  logic [NS-1:0]         adv;
  logic                  in_acc;

  cordic_vec_t           vec  [0:CORDIC_STEPS];
  pt_info_t              info [0:MUL_STAGE];

  logic signed [15:0]          sample;
  logic                        is_eor;
  logic [10:0]                 col_limit;
  logic                        col_open;
  logic                        emit;
  logic signed [21:0]          radius_w;
  logic                        rad_ok;
  logic [31:0]                 angle;
  logic signed [CORDIC_W-1:0]  ang_ext;
  logic signed [CORDIC_W-1:0]  ang_fold;
  logic                        flip;
  logic [21:0]                 z_prod;
  logic [23:0]                 step_wide;
  logic [PHASE_BITS-1:0]       phase_inc;
  pt_info_t                    s0_info;

  logic signed [CORDIC_W-1:0]  cos_full;
  logic signed [CORDIC_W-1:0]  nsin_full;
  logic signed [31:0]          cos32;
  logic signed [31:0]          nsin32;
  logic signed [47:0]          prod_x;
  logic signed [47:0]          prod_y;
  logic signed [47:0]          round_x;
  logic signed [47:0]          round_y;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign in_ready  = adv[0];
  assign out_valid = vld[NS-1];

  // A stage moves on when the output is taken or this or some later stage is empty.
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = out_ready || !(&vld[NS-1:k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_offset  <= 16'sd165;
      z_step         <= 12'd13;
      max_radius     <= 16'sd424;
      min_radius     <= 16'sd0;
      angle_step     <= 16'd256;
      points_per_row <= 10'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_OFFSET:  center_offset  <= cfg_data;
        REG_Z_STEP:         z_step         <= cfg_data[11:0];
        REG_MAX_RADIUS:     max_radius     <= cfg_data;
        REG_MIN_RADIUS:     min_radius     <= cfg_data;
        REG_ANGLE_STEP:     angle_step     <= cfg_data;
        REG_POINTS_PER_ROW: points_per_row <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sample    = raw_value[15] ? 16'sd0 : raw_value;
    is_eor    = (sample == END_OF_ROW);
    col_limit = (11'(points_per_row) < 11'(COLUMN_LIMIT)) ? 11'(points_per_row)
                                                          : 11'(COLUMN_LIMIT);
    col_open  = 11'(column_counter) < col_limit;
    emit      = !rows_full && !is_eor && col_open;

    radius_w  = 22'(center_offset) - $signed({2'b00, sample, 4'b0000});
    rad_ok    = (radius_w >= 22'(min_radius)) && (radius_w <= 22'(max_radius));

    // Fold the angle into the right half plane and turn the result round later.
    angle   = 32'(phase_accumulator) << (32 - PHASE_BITS);
    ang_ext = CORDIC_W'($signed(angle));
    flip    = 1'b0;
    ang_fold = ang_ext;
    if (ang_ext > QUARTER_TURN) begin
      ang_fold = ang_ext - HALF_TURN;
      flip     = 1'b1;
    end else if (ang_ext < -QUARTER_TURN) begin
      ang_fold = ang_ext + HALF_TURN;
      flip     = 1'b1;
    end

    z_prod    = 22'(row_counter) * 22'(z_step);
    step_wide = {angle_step, 8'h00};
    phase_inc = PHASE_BITS'(step_wide >> (24 - PHASE_BITS));

    s0_info.radius        = radius_w[15:0];
    s0_info.point_valid   = rad_ok;
    s0_info.flip          = flip;
    s0_info.z_pos         = (z_prod > 22'(Z_MAX)) ? Z_MAX : z_prod[20:0];
    s0_info.row_number    = row_counter[8:0];
    s0_info.column_number = column_counter[8:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter       <= '0;
      column_counter    <= '0;
      phase_accumulator <= '0;
      rows_full         <= 1'b0;
    end else if (in_acc && !rows_full) begin
      if (is_eor) begin
        column_counter    <= '0;
        phase_accumulator <= '0;
        if ((11'(row_counter) + 11'd1) >= 11'(ROW_LIMIT)) begin
          rows_full <= 1'b1;
        end else begin
          row_counter <= row_counter + 1'b1;
        end
      end else if (col_open) begin
        phase_accumulator <= phase_accumulator + phase_inc;
        column_counter    <= column_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_acc && emit;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      vec[0].x   <= CORDIC_GAIN;
      vec[0].y   <= '0;
      vec[0].ang <= ang_fold;
      info[0]    <= s0_info;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] atan_k;
    cordic_vec_t                nxt;

    assign dx     = vec[k].y >>> k;
    assign dy     = vec[k].x >>> k;
    assign atan_k = CORDIC_W'(ATAN_TURNS[k]);

    always_comb begin
      if (!vec[k].ang[CORDIC_W-1]) begin
        nxt.x   = vec[k].x - dx;
        nxt.y   = vec[k].y + dy;
        nxt.ang = vec[k].ang - atan_k;
      end else begin
        nxt.x   = vec[k].x + dx;
        nxt.y   = vec[k].y - dy;
        nxt.ang = vec[k].ang + atan_k;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k + 1]) begin
        vec[k + 1]  <= nxt;
        info[k + 1] <= info[k];
      end
    end
  end

  // y runs clockwise, so the multiply uses minus sine.
  always_comb begin
    cos_full  = info[CORDIC_STEPS].flip ? -vec[CORDIC_STEPS].x : vec[CORDIC_STEPS].x;
    nsin_full = info[CORDIC_STEPS].flip ? vec[CORDIC_STEPS].y : -vec[CORDIC_STEPS].y;
    cos32     = cos_full[31:0];
    nsin32    = nsin_full[31:0];
  end

  always_ff @(posedge clk) begin
    if (adv[MUL_STAGE]) begin
      prod_x          <= info[CORDIC_STEPS].radius * cos32;
      prod_y          <= info[CORDIC_STEPS].radius * nsin32;
      info[MUL_STAGE] <= info[CORDIC_STEPS];
    end
  end

  always_comb begin
    round_x = (prod_x + 48'sd536870912) >>> 30;
    round_y = (prod_y + 48'sd536870912) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      x_pos         <= info[MUL_STAGE].point_valid ? round_x[19:0] : '0;
      y_pos         <= info[MUL_STAGE].point_valid ? round_y[19:0] : '0;
      z_pos         <= info[MUL_STAGE].z_pos;
      point_valid   <= info[MUL_STAGE].point_valid;
      row_number    <= info[MUL_STAGE].row_number;
      column_number <= info[MUL_STAGE].column_number;
    end
  end

`include "scan_polar_to_cartesian_core_assert.svh"
  `SPC_ASSERT_NEXT(a_rows_full_sticky, rows_full, rows_full)
  `SPC_ASSERT_NEXT(a_full_no_point, in_valid && in_ready && rows_full, !vld[0])
  `SPC_ASSERT_NOW(a_invalid_zero, out_valid && !point_valid, x_pos == '0 && y_pos == '0)

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import spc_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;
  localparam int ROTOR_STEPS   = 20;

  localparam longint ROTOR_GAIN  = 64'sd652032874;
  localparam longint FULL_Q32    = 64'sd4294967296;
  localparam longint HALF_Q32    = 64'sd2147483648;
  localparam longint QUARTER_Q32 = 64'sd1073741824;
  localparam longint ROUND_Q30   = 64'sd536870912;

  // arctan(2^-i) in 2^-32 turns
  localparam longint ARCTAN_Q32 [ROTOR_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518
  };

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic [20:0]        z;
    logic               in_range;
    logic [8:0]         row;
    logic [8:0]         col;
  } scan_point_t;

  class point_scoreboard;
    logic signed [15:0] r_offset, r_max, r_min;
    logic [11:0]        z_inc;
    logic [15:0]        step_turns;
    logic [9:0]         row_points;
    logic [9:0]         row_cnt, col_cnt;
    logic [15:0]        phase;
    bit                 rows_full;
    scan_point_t        due_points[$];
    int                 mismatches;

    function new();
      r_offset   = 16'sd165;
      z_inc      = 12'd13;
      r_max      = 16'sd424;
      r_min      = 16'sd0;
      step_turns = 16'd256;
      row_points = 10'd256;
      row_cnt    = '0;
      col_cnt    = '0;
      phase      = '0;
      rows_full  = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return due_points.size();
    endfunction

    function void set_register(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] d);
      case (idx)
        REG_CENTER_OFFSET:  r_offset = d;
        REG_Z_STEP:         z_inc = d[11:0];
        REG_MAX_RADIUS:     r_max = d;
        REG_MIN_RADIUS:     r_min = d;
        REG_ANGLE_STEP:     step_turns = d;
        REG_POINTS_PER_ROW: row_points = d[9:0];
        default: ;
      endcase
    endfunction

    // Angle in 2^-32 turns; cosine and sine come back in Q2.30.
    function void rotate(input logic [31:0] angle, output longint c, output longint s);
      longint x, y, z, dx, dy;
      bit flip;
      x = ROTOR_GAIN;
      y = 0;
      z = {32'd0, angle};
      flip = 1'b0;
      if (z >= HALF_Q32) z -= FULL_Q32;
      // Fold the left half-plane onto the right one and negate afterwards.
      if (z > QUARTER_Q32) begin
        z -= HALF_Q32;
        flip = 1'b1;
      end else if (z < -QUARTER_Q32) begin
        z += HALF_Q32;
        flip = 1'b1;
      end
      for (int i = 0; i < ROTOR_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= ARCTAN_Q32[i];
        end else begin
          x += dx;
          y -= dy;
          z += ARCTAN_Q32[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void note_sample(input logic signed [15:0] raw);
      int          reading, col_limit;
      longint      r, c, s, xv, yv;
      logic [31:0] zprod;
      scan_point_t p;
      if (rows_full) return;
      reading = (raw < 0) ? 0 : int'(raw);
      if (reading == int'(END_OF_ROW)) begin
        col_cnt = '0;
        phase = '0;
        if (int'(row_cnt) + 1 >= ROW_LIMIT) rows_full = 1'b1;
        else row_cnt = row_cnt + 10'd1;
        return;
      end
      col_limit = (int'(row_points) < COLUMN_LIMIT) ? int'(row_points) : COLUMN_LIMIT;
      if (int'(col_cnt) >= col_limit) return;
      r = longint'(r_offset) - longint'(reading) * 16;
      p.in_range = (r >= longint'(r_min)) && (r <= longint'(r_max));
      xv = 0;
      yv = 0;
      if (p.in_range) begin
        rotate({phase, 16'h0000}, c, s);
        xv = (r * c + ROUND_Q30) >>> 30;
        // The angle runs clockwise, so y takes the negated sine.
        yv = (ROUND_Q30 - r * s) >>> 30;
      end
      zprod = row_cnt * z_inc;
      p.x = 20'(xv);
      p.y = 20'(yv);
      p.z = (zprod > {11'd0, Z_MAX}) ? Z_MAX : zprod[20:0];
      p.row = row_cnt[8:0];
      p.col = col_cnt[8:0];
      due_points.push_back(p);
      phase = phase + step_turns;
      col_cnt = col_cnt + 10'd1;
    endfunction

    function void complain(input string what, input scan_point_t want, input scan_point_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%s: expected x=%0d y=%0d z=%0d valid=%0b row=%0d col=%0d", what,
                 want.x, want.y, want.z, want.in_range, want.row, want.col);
        $display("  actual x=%0d y=%0d z=%0d valid=%0b row=%0d col=%0d",
                 got.x, got.y, got.z, got.in_range, got.row, got.col);
      end
    endfunction

    function void check_point(input scan_point_t got);
      scan_point_t want;
      if (due_points.size() == 0) begin
        complain("point with no request pending", '0, got);
        return;
      end
      want = due_points.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.in_range !== want.in_range || got.row !== want.row || got.col !== want.col)
        complain("point mismatch", want, got);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [15:0]     raw_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [19:0]     x_pos, y_pos;
  logic [20:0]            z_pos;
  logic                   point_valid;
  logic [8:0]             row_number, column_number;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]            cfg_data = '0;

  point_scoreboard sb = new();

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int rx_wait = 0;
  int cur_center = 165;
  int cur_max = 424;
  int cur_min = 0;

  scan_polar_to_cartesian_core dut (.*);

  always #HALF_PERIOD clk = ~clk;

  function automatic int idle_draw();
    return calm ? 0 : int'($urandom_range(0, 11));
  endfunction

  always @(posedge clk) begin
    scan_point_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        got = '{x_pos, y_pos, z_pos, point_valid, row_number, column_number};
        sb.check_point(got);
        rx_wait = idle_draw();
      end
      if (in_valid && in_ready) sb.note_sample(raw_value);
    end
  end

  // The long hold lets the pipeline fill so that the input side has to stall.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_sample(input logic signed [15:0] v);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    raw_value <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_setting(input int center, input int z, input int rmax,
                               input int rmin, input int step, input int ppr);
    cur_center = center;
    cur_max = rmax;
    cur_min = rmin;
    write_reg(REG_CENTER_OFFSET, 16'(center));
    write_reg(REG_Z_STEP, 16'(z));
    write_reg(REG_MAX_RADIUS, 16'(rmax));
    write_reg(REG_MIN_RADIUS, 16'(rmin));
    write_reg(REG_ANGLE_STEP, 16'(step));
    write_reg(REG_POINTS_PER_ROW, 16'(ppr));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly readings whose radius lands near the accepted band, with some noise.
  function automatic logic signed [15:0] pick_sample();
    int roll, lo, hi, target, reading;
    roll = $urandom_range(0, 99);
    if (roll < 12) return 16'($urandom);
    if (roll < 20) return 16'($urandom) | 16'h8000;
    lo = ((cur_min < cur_max) ? cur_min : cur_max) - 40;
    hi = ((cur_min < cur_max) ? cur_max : cur_min) + 40;
    target = lo + int'($urandom_range(0, hi - lo));
    reading = (cur_center - target) >>> 4;
    if (reading > 32767) reading = 32767;
    if (reading < -32768) reading = -32768;
    return 16'(reading);
  endfunction

  task automatic random_setting();
    int center, rmin, rmax, ppr, step;
    case ($urandom_range(0, 5))
      0: center = -32768;
      1: center = 32767;
      default: center = int'($urandom_range(0, 6000)) - 1000;
    endcase
    case ($urandom_range(0, 5))
      0: begin
        rmin = -32768;
        rmax = 32767;
      end
      1: begin
        rmin = 400;
        rmax = 100;
      end
      default: begin
        rmin = int'($urandom_range(0, 600)) - 300;
        rmax = rmin + int'($urandom_range(0, 1500));
      end
    endcase
    case ($urandom_range(0, 7))
      0: ppr = 0;
      1: ppr = 1;
      2: ppr = 512;
      3: ppr = 1023;
      default: ppr = $urandom_range(2, 30);
    endcase
    case ($urandom_range(0, 4))
      0: step = 0;
      1: step = 65535;
      default: step = $urandom_range(0, 65535);
    endcase
    apply_setting(center, $urandom_range(0, 65535), rmax, rmin, step, ppr);
  endtask

  task automatic random_rows(input int n_items);
    int sent, run;
    sent = 0;
    while (sent < n_items) begin
      run = $urandom_range(0, 24);
      repeat (run) begin
        send_sample(pick_sample());
        sent++;
      end
      // Now and then a row is left open and runs on into the next one.
      if ($urandom_range(0, 9) != 0) begin
        send_sample(END_OF_ROW);
        sent++;
      end
    end
  endtask

  initial begin
    #5ms;
    $display("scan_polar_to_cartesian_core verification failed");
    $finish;
  end

  initial begin
    logic signed [15:0] v;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset defaults: clamped negatives, radius below the minimum, widest reading.
    send_sample(16'sd0);
    send_sample(16'sd10);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
    send_sample(16'sd11);
    send_sample(16'sd32767);
    send_sample(16'sd10);
    send_sample(END_OF_ROW);
    send_sample(16'sd3);
    drain();

    // Short rows: the fourth reading of a row is dropped.
    apply_setting(32767, 4095, 32767, -32768, 16384, 3);
    send_sample(16'sd0);
    send_sample(16'sd2047);
    send_sample(16'sd1000);
    send_sample(16'sd5);
    send_sample(END_OF_ROW);
    send_sample(16'sd1);
    drain();

    // Crossed limits mark every point invalid.
    apply_setting(300, 1, 100, 200, 65535, 1023);
    send_sample(16'sd6);
    send_sample(16'sd12);
    send_sample(16'sd18);
    drain();

    // No columns converted at all.
    apply_setting(-32768, 0, 32767, -32768, 0, 0);
    send_sample(16'sd0);
    send_sample(END_OF_ROW);
    send_sample(16'sd7);
    drain();

    for (int k = 0; k < 5; k++) begin
      calm = ($urandom_range(0, 3) == 0);
      random_setting();
      random_rows(30);
      drain();
    end

    // One row past the column limit, with the output held off for a while.
    calm = 1'b0;
    apply_setting(2000, 7, 800, -800, 129, 1023);
    hold_req = 1'b1;
    repeat (530) begin
      v = pick_sample();
      if (v == END_OF_ROW) v = 16'sd0;
      send_sample(v);
    end
    send_sample(END_OF_ROW);
    drain();

    // Run the row counter up to its limit; everything after that is ignored.
    apply_setting(165, 4095, 32767, -32768, $urandom_range(0, 65535), 2);
    while (!sb.rows_full) begin
      if ($urandom_range(0, 15) == 0) begin
        repeat ($urandom_range(1, 3)) send_sample(pick_sample());
      end
      send_sample(END_OF_ROW);
    end
    repeat (20) begin
      if ($urandom_range(0, 1) == 0) send_sample(END_OF_ROW);
      else send_sample(pick_sample());
    end
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("scan_polar_to_cartesian_core verification clean");
    end else begin
      $display("scan_polar_to_cartesian_core verification failed");
    end
    $finish;
  end

endmodule

// File: scan_polar_to_cartesian_core.f
+incdir+rtl
rtl/spc_pkg.sv
rtl/scan_polar_to_cartesian_core.sv
tb/sv/tb_top.sv
